// ----- src/i2cms_pkg.sv -----
// Shared types, codes and phase functions of the I2C master bit sequencer.
package i2cms_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_START = 3'd1,
		MODE_STOP  = 3'd2,
		MODE_WRITE = 3'd3,
		MODE_WAIT  = 3'd4,
		MODE_READ  = 3'd5
	} i2cms_mode_t;

	// Configuration register indexes.
	localparam logic CFG_TICKS_PER_UNIT = 1'b0;
	localparam logic CFG_ACK_TIMEOUT    = 1'b1;

	localparam logic [15:0] TICKS_PER_UNIT_RST = 16'd50;
	localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] write_data;
		logic       send_ack;
		logic       sda_in;
	} i2cms_cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_error;
	} i2cms_res_t;

	typedef struct packed {
		logic [15:0] unit_ticks;
		logic [7:0]  ack_timeout;
	} i2cms_cfg_t;

	typedef struct packed {
		i2cms_mode_t mode;
		logic [2:0]  phase;
		logic [3:0]  bit_cnt;
		logic [7:0]  shift;
		logic [15:0] delay;
		logic [2:0]  units;
		logic [7:0]  tmo;
		logic        scl;
		logic        sda;
		logic        drv;
		logic        ack_flag;
		logic        ack_choice;
		logic [7:0]  rd_byte;
		logic        polling;
	} i2cms_state_t;

	typedef struct packed {
		i2cms_state_t st;
		logic [2:0]   units;
		logic         poll;
	} i2cms_apply_t;

	typedef struct packed {
		i2cms_state_t st;
		logic         fin;
	} i2cms_next_t;

	typedef struct packed {
		i2cms_state_t st;
		logic         done;
	} i2cms_step_t;

	// Set the lines of the current phase and report how long it holds.
	function automatic i2cms_apply_t apply_phase(i2cms_state_t st, logic sda_in);
		i2cms_apply_t r;
		r.st = st;
		r.units = 3'd0;
		r.poll = 1'b0;
		case (st.mode)
			MODE_START: begin
				case (st.phase)
					3'd0: begin
						r.st.drv = 1'b1; r.st.sda = 1'b1; r.st.scl = 1'b1; r.units = 3'd4;
					end
					3'd1: begin
						r.st.sda = 1'b0; r.units = 3'd4;
					end
					default: r.st.scl = 1'b0;
				endcase
			end
			MODE_STOP: begin
				case (st.phase)
					3'd0: begin
						r.st.drv = 1'b1; r.st.scl = 1'b0; r.st.sda = 1'b0; r.units = 3'd4;
					end
					3'd1: begin
						r.st.scl = 1'b1; r.units = 3'd1;
					end
					default: begin
						r.st.sda = 1'b1; r.units = 3'd4;
					end
				endcase
			end
			MODE_WRITE: begin
				case (st.phase)
					3'd0: begin
						r.st.drv = 1'b1; r.st.scl = 1'b0;
					end
					3'd1: begin
						r.st.sda = st.shift[7];
						r.st.shift = {st.shift[6:0], 1'b0};
						r.units = 3'd2;
					end
					3'd2: begin
						r.st.scl = 1'b1; r.units = 3'd2;
					end
					default: begin
						r.st.scl = 1'b0; r.units = 3'd2;
					end
				endcase
			end
			MODE_WAIT: begin
				case (st.phase)
					3'd0: begin
						r.st.drv = 1'b0; r.st.sda = 1'b1; r.units = 3'd1;
					end
					3'd1: begin
						r.st.scl = 1'b1; r.units = 3'd1;
					end
					default: r.poll = 1'b1;
				endcase
			end
			MODE_READ: begin
				case (st.phase)
					3'd0: begin
						r.st.drv = 1'b0; r.st.scl = 1'b0; r.units = 3'd2;
					end
					3'd1: begin
						r.st.scl = 1'b1;
						r.st.shift = {st.shift[6:0], sda_in};
						r.units = 3'd1;
					end
					3'd2: begin
						r.st.scl = 1'b0; r.st.drv = 1'b1; r.st.sda = ~st.ack_choice;
						r.units = 3'd2;
					end
					3'd3: begin
						r.st.scl = 1'b1; r.units = 3'd2;
					end
					default: r.st.scl = 1'b0;
				endcase
			end
			default: r.units = 3'd0;
		endcase
		return r;
	endfunction

	// Pick the phase that follows the current one; fin marks the end of the command.
	function automatic i2cms_next_t next_phase(i2cms_state_t st);
		i2cms_next_t r;
		logic [3:0] cnt;
		r.st = st;
		r.fin = 1'b0;
		cnt = st.bit_cnt + 4'd1;
		case (st.mode)
			MODE_START, MODE_STOP: begin
				if (st.phase >= 3'd2) r.fin = 1'b1;
				else r.st.phase = st.phase + 3'd1;
			end
			MODE_WRITE: begin
				if (st.phase < 3'd3) begin
					r.st.phase = st.phase + 3'd1;
				end else begin
					r.st.bit_cnt = cnt;
					if (cnt < 4'd8) r.st.phase = 3'd1;
					else r.fin = 1'b1;
				end
			end
			MODE_WAIT: begin
				if (st.phase < 3'd2) r.st.phase = st.phase + 3'd1;
				else r.fin = 1'b1;
			end
			MODE_READ: begin
				if (st.phase == 3'd0) begin
					r.st.phase = 3'd1;
				end else if (st.phase == 3'd1) begin
					r.st.bit_cnt = cnt;
					if (cnt < 4'd8) begin
						r.st.phase = 3'd0;
					end else begin
						r.st.rd_byte = st.shift;
						r.st.phase = 3'd2;
					end
				end else if (st.phase >= 3'd4) begin
					r.fin = 1'b1;
				end else begin
					r.st.phase = st.phase + 3'd1;
				end
			end
			default: r.fin = 1'b1;
		endcase
		if (r.fin) begin
			r.st.mode = MODE_IDLE;
			r.st.phase = 3'd0;
		end
		return r;
	endfunction

	// Apply the current phase and chain through a phase with no delay.
	// No reachable sequence holds two zero-delay phases in a row.
	function automatic i2cms_step_t run_phases(i2cms_state_t st, logic sda_in,
		logic [15:0] unit_ticks);
		i2cms_apply_t a;
		i2cms_next_t  n;
		i2cms_step_t  r;
		a = apply_phase(st, sda_in);
		r.done = 1'b0;
		r.st = a.st;
		if (!a.poll && a.units == 3'd0) begin
			n = next_phase(a.st);
			r.st = n.st;
			r.done = n.fin;
			if (!n.fin) begin
				a = apply_phase(n.st, sda_in);
				r.st = a.st;
			end
		end
		if (!r.done) begin
			if (a.poll) begin
				r.st.polling = 1'b1;
				r.st.tmo = 8'd0;
			end else if (a.units != 3'd0) begin
				r.st.units = a.units;
				r.st.delay = unit_ticks;
			end
		end
		return r;
	endfunction

	function automatic i2cms_step_t advance(i2cms_state_t st, logic sda_in,
		logic [15:0] unit_ticks);
		i2cms_next_t n;
		i2cms_step_t r;
		n = next_phase(st);
		if (n.fin) begin
			r.st = n.st;
			r.done = 1'b1;
		end else begin
			r = run_phases(n.st, sda_in, unit_ticks);
		end
		return r;
	endfunction

endpackage

// ----- src/i2c_master_bit_sequencer_core.sv -----
// Top level of the I2C master bit sequencer: state register, result register, handshakes.
//
// Each item on the cmd channel is one bus tick: an optional command (start, stop,
// write byte, wait for acknowledge, read byte) plus the sampled SDA level. A command
// is taken only while the sequencer is idle; otherwise the action is ignored.
// Every accepted item yields exactly one item on the res channel with the driven
// SCL/SDA levels, the SDA output enable, busy, a done pulse, the last read byte
// and the acknowledge error flag, all as they stand after that tick.
// The result of an item is loaded into the result register at the edge that accepts it.
// Throughput is one item per cycle while the receiver does not stall, set by the
// single stage of next-state logic between the state register and the result register.
// When the receiver stalls, cmd_ready drops only while the result register holds
// an item not yet taken, so a stall costs no more than the stalled cycles.
// Reset leaves the sequencer idle with SCL and SDA high and driven, the unit
// length at 50 ticks and the acknowledge timeout at 250 ticks. The configuration
// port writes a register on any edge with cfg_we high; write it only while idle.
module i2c_master_bit_sequencer_core
	import i2cms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  i2cms_cmd_t  cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output i2cms_res_t  res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	localparam i2cms_state_t STATE_RST = '{
		mode: MODE_IDLE, phase: 3'd0, bit_cnt: 4'd0, shift: 8'd0, delay: 16'd0,
		units: 3'd0, tmo: 8'd0, scl: 1'b1, sda: 1'b1, drv: 1'b1, ack_flag: 1'b0,
		ack_choice: 1'b0, rd_byte: 8'd0, polling: 1'b0
	};

	i2cms_cfg_t   cfg;
	i2cms_state_t state_q;
	i2cms_state_t state_nxt;
	i2cms_res_t   res_nxt;
	i2cms_res_t   res_q;
	logic         res_valid_q;
	logic         accept;

	i2cms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cms_step u_step (
		.st     (state_q),
		.cmd    (cmd),
		.cfg    (cfg),
		.st_nxt (state_nxt),
		.res    (res_nxt)
	);

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_done_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res |-> !res.busy_res)
		else $error("done reported while a command is still running");

	a_poll_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.polling |-> state_q.mode == MODE_WAIT)
		else $error("acknowledge polling outside a wait command");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && state_q.mode == MODE_IDLE && cmd.action == 3'd0
		|=> state_q.mode == MODE_IDLE)
		else $error("sequencer left idle without a command");

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_cnt <= 4'd8)
		else $error("bit counter ran past one byte");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid)
		else $error("input stalled with an empty result register");

endmodule

// ----- src/i2cms_cfg.sv -----
// Configuration registers of the I2C master bit sequencer.
module i2cms_cfg
	import i2cms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	output i2cms_cfg_t  cfg
);

	logic [15:0] ticks_q;
	logic [7:0]  timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= TICKS_PER_UNIT_RST;
			timeout_q <= ACK_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TICKS_PER_UNIT: ticks_q   <= cfg_wdata;
				CFG_ACK_TIMEOUT:    timeout_q <= cfg_wdata[7:0];
				default:            ticks_q   <= ticks_q;
			endcase
		end
	end

	// A unit length of zero behaves as one tick.
	assign cfg.unit_ticks  = (ticks_q == 16'd0) ? 16'd1 : ticks_q;
	assign cfg.ack_timeout = timeout_q;

endmodule

// ----- src/i2cms_step.sv -----
// Next-state and result logic for one tick of the I2C master bit sequencer.
module i2cms_step
	import i2cms_pkg::*;
(
	input  i2cms_state_t st,
	input  i2cms_cmd_t   cmd,
	input  i2cms_cfg_t   cfg,
	output i2cms_state_t st_nxt,
	output i2cms_res_t   res
);

	i2cms_state_t seed;
	i2cms_step_t  stp;
	logic [15:0]  delay_dec;
	logic [2:0]   units_dec;

	always_comb begin
		seed = st;
		stp.st = st;
		stp.done = 1'b0;
		delay_dec = (st.delay != 16'd0) ? st.delay - 16'd1 : st.delay;
		units_dec = (st.units != 3'd0) ? st.units - 3'd1 : st.units;

		if (st.mode == MODE_IDLE) begin
			if (cmd.action inside {[MODE_START:MODE_READ]}) begin
				seed.mode = i2cms_mode_t'(cmd.action);
				seed.phase = 3'd0;
				seed.bit_cnt = 4'd0;
				seed.polling = 1'b0;
				if (cmd.action == MODE_WRITE) seed.shift = cmd.write_data;
				if (cmd.action == MODE_READ) begin
					seed.shift = 8'd0;
					seed.ack_choice = cmd.send_ack;
				end
				stp = run_phases(seed, cmd.sda_in, cfg.unit_ticks);
			end
		end else if (st.polling) begin
			if (!cmd.sda_in) begin
				stp.st.polling = 1'b0;
				stp.st.scl = 1'b0;
				stp.st.ack_flag = 1'b0;
				stp.st.mode = MODE_IDLE;
				stp.st.phase = 3'd0;
				stp.done = 1'b1;
			end else if (st.tmo >= cfg.ack_timeout) begin
				// No acknowledge in time: flag it and put a stop on the bus.
				seed.polling = 1'b0;
				seed.ack_flag = 1'b1;
				seed.mode = MODE_STOP;
				seed.phase = 3'd0;
				stp = run_phases(seed, cmd.sda_in, cfg.unit_ticks);
			end else begin
				stp.st.tmo = st.tmo + 8'd1;
			end
		end else begin
			seed.delay = delay_dec;
			if (delay_dec == 16'd0) begin
				seed.units = units_dec;
				if (units_dec == 3'd0) begin
					stp = advance(seed, cmd.sda_in, cfg.unit_ticks);
				end else begin
					stp.st = seed;
					stp.st.delay = cfg.unit_ticks;
				end
			end else begin
				stp.st = seed;
			end
		end
	end

	assign st_nxt = stp.st;

	assign res.scl_level = stp.st.scl;
	assign res.sda_level = stp.st.sda;
	assign res.sda_drive = stp.st.drv;
	assign res.busy_res  = (stp.st.mode != MODE_IDLE);
	assign res.done_res  = stp.done;
	assign res.read_data = stp.st.rd_byte;
	assign res.ack_error = stp.st.ack_flag;

endmodule

// ----- tb/testbench.sv -----
// Testbench for the I2C master bit sequencer: directed and random bus ticks checked against a tick predictor.
module testbench;
	import i2cms_pkg::*;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_BAD_LO = 3'd6;
	localparam logic [2:0] ACT_BAD_HI = 3'd7;
	localparam int PHASE_END   = 15;
	localparam int POLL_UNITS  = 255;
	localparam int NEVER_LOW   = 1000000;
	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_TICKS = 60;

	// Tracks the bus lines tick by tick and checks every result item against them.
	class i2c_tick_scoreboard;
		logic [15:0] unit_ticks_reg;
		logic [7:0]  ack_timeout_reg;
		i2cms_mode_t mode;
		int          phase;
		logic [3:0]  bit_cnt;
		logic [7:0]  shift_reg;
		logic [15:0] delay_cnt;
		logic [7:0]  units_left;
		logic [7:0]  wait_cnt;
		logic        scl, sda, drv;
		logic        ack_flag, ack_choice;
		logic [7:0]  rd_byte;
		logic        polling;
		i2cms_res_t  expected_lines[$];
		int unsigned errors, ticks, commands, ignored, dones, ack_timeouts;

		function new();
			unit_ticks_reg = TICKS_PER_UNIT_RST;
			ack_timeout_reg = ACK_TIMEOUT_RST;
			mode = MODE_IDLE;
			phase = 0;
			bit_cnt = '0;
			shift_reg = '0;
			delay_cnt = '0;
			units_left = '0;
			wait_cnt = '0;
			scl = 1'b1;
			sda = 1'b1;
			drv = 1'b1;
			ack_flag = 1'b0;
			ack_choice = 1'b0;
			rd_byte = '0;
			polling = 1'b0;
			errors = 0;
			ticks = 0;
			commands = 0;
			ignored = 0;
			dones = 0;
			ack_timeouts = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] val);
			if (idx == CFG_TICKS_PER_UNIT) unit_ticks_reg = val;
			else ack_timeout_reg = val[7:0];
		endfunction

		// A unit length of zero behaves as one tick.
		function logic [15:0] unit_len();
			return (unit_ticks_reg == 16'd0) ? 16'd1 : unit_ticks_reg;
		endfunction

		function bit busy();
			return mode != MODE_IDLE;
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction

		// Sets the lines of the current phase and returns how many units it holds.
		function int drive_phase(logic sda_in);
			int u;
			u = 0;
			case (mode)
				MODE_START:
					case (phase)
						0: begin
							drv = 1'b1; sda = 1'b1; scl = 1'b1; u = 4;
						end
						1: begin
							sda = 1'b0; u = 4;
						end
						default: scl = 1'b0;
					endcase
				MODE_STOP:
					case (phase)
						0: begin
							drv = 1'b1; scl = 1'b0; sda = 1'b0; u = 4;
						end
						1: begin
							scl = 1'b1; u = 1;
						end
						default: begin
							sda = 1'b1; u = 4;
						end
					endcase
				MODE_WRITE:
					case (phase)
						0: begin
							drv = 1'b1; scl = 1'b0;
						end
						1: begin
							sda = shift_reg[7];
							shift_reg = {shift_reg[6:0], 1'b0};
							u = 2;
						end
						2: begin
							scl = 1'b1; u = 2;
						end
						default: begin
							scl = 1'b0; u = 2;
						end
					endcase
				MODE_WAIT:
					case (phase)
						0: begin
							drv = 1'b0; sda = 1'b1; u = 1;
						end
						1: begin
							scl = 1'b1; u = 1;
						end
						default: u = POLL_UNITS;
					endcase
				MODE_READ:
					case (phase)
						0: begin
							drv = 1'b0; scl = 1'b0; u = 2;
						end
						1: begin
							scl = 1'b1;
							shift_reg = {shift_reg[6:0], sda_in};
							u = 1;
						end
						2: begin
							scl = 1'b0; drv = 1'b1; sda = ~ack_choice; u = 2;
						end
						3: begin
							scl = 1'b1; u = 2;
						end
						default: scl = 1'b0;
					endcase
				default: u = 0;
			endcase
			return u;
		endfunction

		function int pick_next_phase();
			int nxt;
			nxt = PHASE_END;
			case (mode)
				MODE_START, MODE_STOP: nxt = (phase >= 2) ? PHASE_END : phase + 1;
				MODE_WRITE: begin
					if (phase < 3) begin
						nxt = phase + 1;
					end else begin
						bit_cnt = bit_cnt + 4'd1;
						nxt = (bit_cnt < 4'd8) ? 1 : PHASE_END;
					end
				end
				MODE_WAIT: nxt = (phase < 2) ? phase + 1 : PHASE_END;
				MODE_READ: begin
					if (phase == 0) begin
						nxt = 1;
					end else if (phase == 1) begin
						bit_cnt = bit_cnt + 4'd1;
						if (bit_cnt < 4'd8) begin
							nxt = 0;
						end else begin
							rd_byte = shift_reg;
							nxt = 2;
						end
					end else begin
						nxt = (phase >= 4) ? PHASE_END : phase + 1;
					end
				end
				default: nxt = PHASE_END;
			endcase
			return nxt;
		endfunction

		function void go_idle();
			mode = MODE_IDLE;
			phase = 0;
		endfunction

		// Applies phases until one holds for a while or the command ends; returns done.
		function bit chain_phases(logic sda_in);
			int u;
			bit fin, settled;
			fin = 1'b0;
			settled = 1'b0;
			for (int g = 0; g < 8 && !settled; g++) begin
				u = drive_phase(sda_in);
				if (u == POLL_UNITS) begin
					polling = 1'b1;
					wait_cnt = '0;
					settled = 1'b1;
				end else if (u != 0) begin
					units_left = u[7:0];
					delay_cnt = unit_len();
					settled = 1'b1;
				end else begin
					phase = pick_next_phase();
					if (phase == PHASE_END) begin
						go_idle();
						fin = 1'b1;
						settled = 1'b1;
					end
				end
			end
			return fin;
		endfunction

		function bit finish_phase(logic sda_in);
			phase = pick_next_phase();
			if (phase == PHASE_END) begin
				go_idle();
				return 1'b1;
			end
			return chain_phases(sda_in);
		endfunction

		// Notes one accepted tick and queues the lines expected after it.
		function void note_tick(i2cms_cmd_t c);
			bit done;
			i2cms_res_t r;
			done = 1'b0;
			ticks++;
			if (mode == MODE_IDLE) begin
				if (c.action >= MODE_START && c.action <= MODE_READ) begin
					mode = i2cms_mode_t'(c.action);
					phase = 0;
					bit_cnt = '0;
					polling = 1'b0;
					if (mode == MODE_WRITE) shift_reg = c.write_data;
					if (mode == MODE_READ) begin
						shift_reg = '0;
						ack_choice = c.send_ack;
					end
					commands++;
					done = chain_phases(c.sda_in);
				end else if (c.action != ACT_NONE) begin
					ignored++;
				end
			end else begin
				if (c.action != ACT_NONE) ignored++;
				if (polling) begin
					if (!c.sda_in) begin
						polling = 1'b0;
						scl = 1'b0;
						ack_flag = 1'b0;
						go_idle();
						done = 1'b1;
					end else if (wait_cnt >= ack_timeout_reg) begin
						// No acknowledge: flag it and release the bus with a stop.
						polling = 1'b0;
						ack_flag = 1'b1;
						ack_timeouts++;
						mode = MODE_STOP;
						phase = 0;
						done = chain_phases(c.sda_in);
					end else begin
						wait_cnt++;
					end
				end else begin
					if (delay_cnt > 0) delay_cnt--;
					if (delay_cnt == 0) begin
						if (units_left > 0) units_left--;
						if (units_left == 0) done = finish_phase(c.sda_in);
						else delay_cnt = unit_len();
					end
				end
			end
			if (done) dones++;
			r.scl_level = scl;
			r.sda_level = sda;
			r.sda_drive = drv;
			r.busy_res = (mode != MODE_IDLE);
			r.done_res = done;
			r.read_data = rd_byte;
			r.ack_error = ack_flag;
			expected_lines.push_back(r);
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(i2cms_res_t got);
			i2cms_res_t want;
			if (expected_lines.size() == 0) begin
				$error("result item arrived with no tick waiting for it");
				errors++;
			end else begin
				want = expected_lines.pop_front();
				check_field("scl_level", {7'd0, want.scl_level}, {7'd0, got.scl_level});
				check_field("sda_level", {7'd0, want.sda_level}, {7'd0, got.sda_level});
				check_field("sda_drive", {7'd0, want.sda_drive}, {7'd0, got.sda_drive});
				check_field("busy_res", {7'd0, want.busy_res}, {7'd0, got.busy_res});
				check_field("done_res", {7'd0, want.done_res}, {7'd0, got.done_res});
				check_field("read_data", want.read_data, got.read_data);
				check_field("ack_error", {7'd0, want.ack_error}, {7'd0, got.ack_error});
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	i2cms_cmd_t  cmd;
	logic        res_valid;
	logic        res_ready;
	i2cms_res_t  res;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_wdata;

	i2c_tick_scoreboard sb;
	int sender_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_cnt = 0;

	i2c_master_bit_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) sb.check_result(res);
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				res_ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
				res_ready <= 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[7:0];
	endfunction

	function automatic logic rand_bit();
		logic [31:0] r;
		r = $urandom;
		return r[0];
	endfunction

	// Tick sent while a command runs; now and then it carries a command that must be ignored.
	function automatic i2cms_cmd_t busy_tick();
		i2cms_cmd_t c;
		logic [31:0] r;
		r = $urandom;
		c.action = (r[31:28] < 4'd3) ? r[2:0] : ACT_NONE;
		c.write_data = r[10:3];
		c.send_ack = r[11];
		c.sda_in = r[12];
		return c;
	endfunction

	task automatic send_tick(input i2cms_cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		sb.note_tick(c);
	endtask

	// Issues one command and keeps ticking until it is done. SDA is random when high_ticks
	// is negative, else high for that many ticks and low after.
	task automatic run_command(input logic [2:0] act, input logic [7:0] data,
		input logic ack, input int high_ticks);
		i2cms_cmd_t c;
		int n;
		n = 0;
		c.action = act;
		c.write_data = data;
		c.send_ack = ack;
		c.sda_in = (high_ticks < 0) ? rand_bit() : (n < high_ticks);
		send_tick(c);
		while (sb.busy()) begin
			n++;
			c = busy_tick();
			c.sda_in = (high_ticks < 0) ? rand_bit() : (n < high_ticks);
			send_tick(c);
		end
	endtask

	task automatic run_wait_ack();
		int lead;
		int sel;
		lead = 2 * sb.unit_len();
		sel = $urandom_range(99);
		if (sel < 70)
			run_command(MODE_WAIT, rand_byte(), rand_bit(),
				lead + $urandom_range(0, sb.ack_timeout_reg + 1));
		else if (sel < 85)
			run_command(MODE_WAIT, rand_byte(), rand_bit(), NEVER_LOW);
		else
			run_command(MODE_WAIT, rand_byte(), rand_bit(), -1);
	endtask

	// Registers change only with nothing in flight and the sequencer idle.
	task automatic set_regs(input int unit_ticks, input int ack_tmo);
		logic [31:0] r;
		logic [15:0] tmo_word;
		r = $urandom;
		tmo_word = {r[7:0], ack_tmo[7:0]};
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICKS_PER_UNIT;
		cfg_wdata <= unit_ticks[15:0];
		@(posedge clk);
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_wdata <= tmo_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(CFG_TICKS_PER_UNIT, unit_ticks[15:0]);
		sb.write_reg(CFG_ACK_TIMEOUT, tmo_word);
	endtask

	task automatic set_idling(input int sel);
		case (sel)
			0: begin
				sender_idle_pct = 0;
				rx_stall_pct <= 0;
			end
			1: begin
				sender_idle_pct = 87;
				rx_stall_pct <= 0;
			end
			2: begin
				sender_idle_pct = 0;
				rx_stall_pct <= 87;
			end
			default: begin
				sender_idle_pct = 13;
				rx_stall_pct <= 13;
			end
		endcase
	endtask

	initial begin
		int unsigned goal;
		logic [31:0] r;
		sb = new();
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_we <= 1'b0;
		cfg_index <= 1'b0;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, starting from the reset register values.
		run_command(MODE_WAIT, 8'h00, 1'b0, 0);
		set_regs(1, 3);
		run_command(ACT_NONE, 8'hFF, 1'b1, -1);
		run_command(ACT_BAD_LO, 8'h00, 1'b0, -1);
		run_command(ACT_BAD_HI, 8'hFF, 1'b1, -1);
		run_command(MODE_START, 8'h00, 1'b0, -1);
		run_command(MODE_WRITE, 8'hFF, 1'b0, -1);
		run_command(MODE_WAIT, 8'h00, 1'b0, 0);
		// The acknowledge comes on the last sample before the timeout.
		run_command(MODE_WAIT, 8'h00, 1'b0, 6);
		run_command(MODE_WAIT, 8'h00, 1'b0, NEVER_LOW);
		run_command(MODE_START, 8'h00, 1'b0, -1);
		run_command(MODE_READ, 8'h00, 1'b1, -1);
		run_command(MODE_READ, 8'h00, 1'b1, NEVER_LOW);
		run_command(MODE_READ, 8'hFF, 1'b0, 0);
		run_command(MODE_STOP, 8'h00, 1'b0, -1);
		// A zero unit length runs as one tick; a zero timeout fails on the first high sample.
		set_regs(0, 0);
		run_command(MODE_WAIT, 8'h00, 1'b0, NEVER_LOW);
		run_command(MODE_WAIT, 8'h00, 1'b0, 0);

		// Random part: loose commands under each idling pattern in turn.
		for (int p = 0; p < 4; p++) begin
			r = $urandom;
			case (p)
				1: set_regs(1, 0);
				2: set_regs(2, r[11:8] % 13);
				3: set_regs(0, 1);
				default: set_regs(1, r[11:8] % 13);
			endcase
			set_idling(p);
			if (p % 2 == 0) hold_reqs <= hold_reqs + 1;
			goal = sb.ticks + PHASE_TICKS;
			while (sb.ticks < goal) begin
				r = $urandom;
				if (r[10:8] == MODE_WAIT) run_wait_ack();
				else run_command(r[10:8], rand_byte(), rand_bit(), -1);
			end
		end

		cmd_valid <= 1'b0;
		rx_stall_pct <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("Ran %0d bus ticks with %0d commands (%0d ignored), %0d done pulses,",
			sb.ticks, sb.commands, sb.ignored, sb.dones);
		$display("%0d acknowledge timeouts, unit lengths of 0 to 50 ticks, all idling patterns.",
			sb.ack_timeouts);
		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- i2c_master_bit_sequencer_core.f -----
src/i2cms_pkg.sv
src/i2cms_cfg.sv
src/i2cms_step.sv
src/i2c_master_bit_sequencer_core.sv
tb/testbench.sv
